[design/icmpenc_pkg.sv]
// Package for the ICMP echo encapsulator.
// Holds the buffer sizes, header layout and ICMP type codes; no dependencies.
`default_nettype none

package icmpenc_pkg;

    localparam int MAX_PAYLOAD  = 2048;
    localparam int ADDR_W       = $clog2(MAX_PAYLOAD);
    localparam int CNT_W        = $clog2(MAX_PAYLOAD + 1);
    localparam int HEADER_BYTES = 8;

    localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

endpackage

`default_nettype wire

[design/icmpenc_if.sv]
// Channel interfaces of the ICMP echo encapsulator: input, output and config.
// Each carries valid, ready and its payload; no package dependencies.
`default_nettype none

interface icmpenc_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, output cmd, output data_byte, output last, input ready);
    modport sink   (input valid, input cmd, input data_byte, input last, output ready);
endinterface

interface icmpenc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       truncated;
    modport source (output valid, output out_byte, output out_last, output truncated,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input truncated,
                    output ready);
endinterface

interface icmpenc_cfg_if;
    logic valid;
    logic ready;
    logic reply_mode;
    modport source (output valid, output reply_mode, input ready);
    modport sink   (input valid, input reply_mode, output ready);
endinterface

`default_nettype wire

[design/icmpenc_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the payload buffer.
`default_nettype none

module icmpenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/icmp_echo_encapsulator_unit.sv]
// ICMP echo encapsulator top level. Depends on icmpenc_pkg, icmpenc_if and icmpenc_ram.
// A push word is absorbed in the cycle it is accepted; a pull word returns its packet
// byte through the pending stage (payload RAM read or header byte), then the output register.
// One word per cycle is sustained while the output side keeps ready high; the RAM read
// port's registered read lies on the pull path. Reset clears all control state
// at once; the payload RAM needs no clearing pass, since only written entries are read.
`default_nettype none

module icmp_echo_encapsulator_unit
    import icmpenc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    icmpenc_in_if.sink    i_in,
    icmpenc_cfg_if.sink   i_cfg,
    icmpenc_out_if.source o_out
);

    typedef enum logic {
        PH_LOAD,
        PH_EMIT
    } t_phase;

    // Packet state.
    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [31:0]        r_sum, n_sum;
    logic [7:0]         r_hold, n_hold;
    logic [CNT_W-1:0]   r_emit, n_emit;
    logic               r_ovf, n_ovf;
    logic [7:0]         r_type, n_type;
    logic [15:0]        r_chk, n_chk;
    logic               r_reply_mode;

    // Pending stage: a pull whose RAM read is in flight or waiting for the output slot.
    logic               r_pend;
    logic               r_pend_ram;
    logic [7:0]         r_pend_hdr;
    logic               r_pend_last;
    logic               r_pend_trunc;

    // Output register.
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_trunc;

    logic               in_acc, push, pull, move, room, fin, use_ram;
    logic [31:0]        sum_fin;
    logic [16:0]        fold1, fold2;
    logic [7:0]         hdr_byte;
    logic [CNT_W-1:0]   p_next;
    logic [CNT_W-1:0]   payload_idx;
    logic [7:0]         ram_rdata;

    // The pending word moves to the output register when that register is free or
    // drained in this cycle; a new word is taken whenever the pending stage frees up.
    assign move       = r_pend && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_pend || move;
    assign i_cfg.ready = 1'b1;
    assign in_acc     = i_in.valid && i_in.ready;
    assign push       = in_acc && (i_in.cmd == CMD_PUSH) && (r_phase != PH_EMIT);
    assign pull       = in_acc && (i_in.cmd == CMD_PULL) && (r_phase == PH_EMIT);
    assign room       = r_count < CNT_W'(MAX_PAYLOAD);

    assign p_next      = r_emit + CNT_W'(1);
    assign fin         = p_next == (r_count + CNT_W'(HEADER_BYTES));
    assign use_ram     = r_emit >= CNT_W'(HEADER_BYTES);
    assign payload_idx = r_emit - CNT_W'(HEADER_BYTES);

    // Header bytes: type, zero code, checksum high then low, zero identifier/sequence.
    always_comb begin
        priority if (r_emit == CNT_W'(0)) begin
            hdr_byte = r_type;
        end else if (r_emit == CNT_W'(2)) begin
            hdr_byte = r_chk[15:8];
        end else if (r_emit == CNT_W'(3)) begin
            hdr_byte = r_chk[7:0];
        end else begin
            hdr_byte = 8'd0;
        end
    end

    // Next packet state. A push with room stores the byte and adds a finished big-endian word
    // to the sum, else it sets the overflow flag; the last push also adds a pending odd byte
    // and the type word, then folds the carries twice and inverts to form the checksum.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_sum   = r_sum;
        n_hold  = r_hold;
        n_emit  = r_emit;
        n_ovf   = r_ovf;
        n_type  = r_type;
        n_chk   = r_chk;
        sum_fin = 32'd0;
        fold1   = 17'd0;
        fold2   = 17'd0;
        if (push) begin
            if (room) begin
                if (!r_count[0]) begin
                    n_hold = i_in.data_byte;
                end else begin
                    n_sum = r_sum + {16'd0, r_hold, i_in.data_byte};
                end
                n_count = r_count + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
            if (i_in.last) begin
                n_type  = r_reply_mode ? TYPE_ECHO_REPLY : TYPE_ECHO_REQUEST;
                sum_fin = n_sum + (n_count[0] ? {16'd0, n_hold, 8'd0} : 32'd0)
                        + {16'd0, n_type, 8'd0};
                fold1   = {1'b0, sum_fin[31:16]} + {1'b0, sum_fin[15:0]};
                fold2   = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
                n_chk   = ~fold2[15:0];
                n_sum   = 32'd0;
                n_phase = PH_EMIT;
                n_emit  = '0;
            end
        end else if (pull) begin
            if (fin) begin
                // End of packet: back to loading with an empty buffer.
                n_phase = PH_LOAD;
                n_count = '0;
                n_sum   = 32'd0;
                n_hold  = 8'd0;
                n_emit  = '0;
                n_ovf   = 1'b0;
            end else begin
                n_emit = p_next;
            end
        end
    end

    icmpenc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push && room),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.data_byte),
        .i_re    (pull && use_ram),
        .i_raddr (payload_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LOAD;
            r_count      <= '0;
            r_sum        <= 32'd0;
            r_hold       <= 8'd0;
            r_emit       <= '0;
            r_ovf        <= 1'b0;
            r_type       <= TYPE_ECHO_REQUEST;
            r_reply_mode <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_hold  <= n_hold;
            r_emit  <= n_emit;
            r_ovf   <= n_ovf;
            r_type  <= n_type;
            if (i_cfg.valid && i_cfg.ready) begin
                r_reply_mode <= i_cfg.reply_mode;
            end
            if (pull) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_chk <= n_chk;
        if (pull) begin
            r_pend_ram   <= use_ram;
            r_pend_hdr   <= hdr_byte;
            r_pend_last  <= fin;
            r_pend_trunc <= fin && r_ovf;
        end
        if (move) begin
            r_out_byte  <= r_pend_ram ? ram_rdata : r_pend_hdr;
            r_out_last  <= r_pend_last;
            r_out_trunc <= r_pend_trunc;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.out_last  = r_out_last;
    assign o_out.truncated = r_out_trunc;

endmodule

`default_nettype wire

[design/icmpenc_checker.sv]
// Port-level checker for the ICMP echo encapsulator, with its bind statement.
// Depends on icmpenc_pkg and the top level icmp_echo_encapsulator_unit.
`default_nettype none

module icmpenc_checker
    import icmpenc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_cmd,
    input wire logic i_cfg_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_last,
    input wire logic i_out_truncated
);

    // A stalled output word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // Truncation is only reported on the final byte of a packet.
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_out_truncated)
        else $error("truncated flag set on a non-final byte");

    // A fresh output word always follows an accepted pull: the pull
    // fills the pending stage, which moves into the empty output register next.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && (i_in_cmd == CMD_PULL), 2))
        else $error("output word without a preceding pull");

    // The configuration register is always writable.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind icmp_echo_encapsulator_unit icmpenc_checker u_icmpenc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_cmd        (i_in.cmd),
    .i_cfg_ready     (i_cfg.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_last      (o_out.out_last),
    .i_out_truncated (o_out.truncated)
);

`default_nettype wire
